### rtl/ship_drrip_stream_bypass_replacement_assert.svh
// Assertion macros for the replacement engine.
// Included by rtl/ship_drrip_stream_bypass_replacement.sv.
`ifndef SHIP_DRRIP_STREAM_BYPASS_REPLACEMENT_ASSERT_SVH
`define SHIP_DRRIP_STREAM_BYPASS_REPLACEMENT_ASSERT_SVH
// Implication checked every cycle outside reset.
`define SDR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SDR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/sdrr_pkg.sv
// Package: payload structs and fixed constants for the replacement engine.
// No dependencies.
`timescale 1ns / 1ps
package sdrr_pkg;
   localparam int ADDR_W = 48;
   localparam int SETS = 2048;
   localparam int WAYS = 16;
   localparam int SIG_WIDTH = 6;
   localparam int SELECTOR_WIDTH = 10;
   localparam int SET_W = $clog2(SETS);
   localparam int WAY_W = $clog2(WAYS);
   localparam logic CMD_VICTIM = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;
   localparam logic CSR_STREAM_THR = 1'b0;
   localparam logic CSR_REUSE_THR = 1'b1;
   localparam logic [1:0] RRPV_MAX = 2'd3;
   localparam logic [1:0] RRPV_LONG = 2'd2;
   localparam logic [1:0] RRPV_NEAR = 2'd0;
   localparam logic signed [2:0] SCORE_MAX = 3'sd3;
   localparam logic signed [2:0] SCORE_MIN = -3'sd4;
   localparam logic [ADDR_W-1:0] STRIDE = 48'd64;

   typedef struct packed {
      logic                cmd;
      logic [SET_W-1:0]    set_index;
      logic [WAY_W-1:0]    way_index;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   pc;
      logic                hit;
   } req_type;

   typedef struct packed {
      logic [WAY_W-1:0]          victim_way;
      logic                      set_streaming;
      logic [SELECTOR_WIDTH-1:0] selector_now;
   } rsp_type;
endpackage

### rtl/ship_drrip_stream_bypass_replacement.sv
// Top level: SHiP/DRRIP replacement engine with per-set stream detection.
// Depends on sdrr_pkg and ship_drrip_stream_bypass_replacement_assert.svh.
// A request passes the read, counter read, train, modify/write and respond states before rsp_valid;
// a new request is taken only after the previous response is issued, set read-modify-write bound.
// Reset sweeps all SETS rows of the set and line memories, counters alongside.
// Every DECAY_INTERVAL-th update adds a counter decay sweep over all 2^SIG_WIDTH counters.
`timescale 1ns / 1ps
`include "ship_drrip_stream_bypass_replacement_assert.svh"
module ship_drrip_stream_bypass_replacement #(
   parameter int LEADERS = 32,
   parameter int DECAY_INTERVAL = 16384
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdrr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdrr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [2:0]       csr_wdata
);
   import sdrr_pkg::*;

   localparam int NSIGS = 1 << SIG_WIDTH;
   localparam int CNT_W = $clog2(DECAY_INTERVAL);
   localparam int SW = SELECTOR_WIDTH;
   localparam logic [SW-1:0] SEL_MID = SW'(1) << (SW - 1);
   localparam logic [SW-1:0] SEL_MAX = '1;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b00000001,
      ST_IDLE   = 8'b00000010,
      ST_READ   = 8'b00000100,
      ST_SIGRD  = 8'b00001000,
      ST_TRAIN  = 8'b00010000,
      ST_MODIFY = 8'b00100000,
      ST_DECAY  = 8'b01000000,
      ST_RESP   = 8'b10000000
   } state_type;

   typedef struct packed {
      logic [WAYS-1:0][1:0]         rrpv;
      logic [WAYS-1:0][SIG_WIDTH-1:0] sig;
   } row_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prev;
      logic signed [2:0] score;
   } setrow_type;

   // memories
   row_type    line_mem [SETS];
   setrow_type set_mem [SETS];
   logic [1:0] sctr_ff [NSIGS];

   row_type    line_rd_ff;
   setrow_type set_rd_ff;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   rsp_type   res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [SET_W:0] clr_ff, clr_in;
   logic [SIG_WIDTH:0] dec_ff, dec_in;
   logic signed [2:0] sthr_ff, sthr_in;
   logic [1:0] rthr_ff, rthr_in;
   logic [SW-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0] ucnt_ff, ucnt_in;
   logic [1:0] ctr_new_ff, ctr_new_in;

   logic mem_we;
   logic [SET_W-1:0] mem_wa;
   row_type row_w;
   setrow_type set_w;
   logic sig_we;
   logic [SIG_WIDTH-1:0] sig_wa;
   logic [1:0] sig_wd;
   logic [SIG_WIDTH-1:0] sig_rd_a;
   logic [1:0] sig_rd_ff;

   logic [SET_W-1:0] cur_set;
   logic [WAY_W-1:0] cur_way;
   logic [SIG_WIDTH-1:0] new_sig, old_sig, train_sig;
   logic [1:0] top_v;
   logic [WAY_W-1:0] first_w;
   logic [ADDR_W:0] a_x, p_x;
   logic signed [2:0] score_nx;
   logic streaming;
   logic [CNT_W-1:0] ucnt_nx;
   logic lead_s, lead_b, brrip_far;
   logic [1:0] ins_v;
   logic [1:0] ctr_pick, ctr_eff;

   assign cur_set = req_ff.set_index;
   assign cur_way = req_ff.way_index;
   assign new_sig = SIG_WIDTH'(req_ff.pc ^ (req_ff.address >> 6));
   assign old_sig = line_rd_ff.sig[cur_way];
   assign train_sig = req_ff.hit ? new_sig : old_sig;
   assign a_x = {1'b0, req_ff.address};
   assign p_x = {1'b0, set_rd_ff.prev};
   assign ucnt_nx = (ucnt_ff == CNT_W'(DECAY_INTERVAL - 1)) ? '0 : ucnt_ff + 1'b1;
   assign lead_s = 32'(cur_set) < 32'(LEADERS);
   assign lead_b = !lead_s && 32'(cur_set) < 32'(2 * LEADERS);
   assign brrip_far = ucnt_nx[2:0] != 3'd0;
   // same entry as the trained one: take the trained value, then apply a pending decay
   assign ctr_pick = (new_sig == train_sig) ? ctr_new_ff : sig_rd_ff;
   assign ctr_eff = (ucnt_nx == '0 && ctr_pick != 2'd0) ? ctr_pick - 2'd1 : ctr_pick;

   always_comb begin
      top_v = '0;
      first_w = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (line_rd_ff.rrpv[w] > top_v) begin
            top_v = line_rd_ff.rrpv[w];
            first_w = WAY_W'(w);
         end
      end
   end

   always_comb begin
      score_nx = set_rd_ff.score;
      if (a_x == p_x + 49'(STRIDE) || p_x == a_x + 49'(STRIDE)) begin
         if (score_nx != SCORE_MAX) score_nx = score_nx + 3'sd1;
      end else if (a_x != p_x) begin
         if (score_nx != SCORE_MIN) score_nx = score_nx - 3'sd1;
      end
   end

   assign streaming = (req_ff.cmd == CMD_UPDATE ? score_nx : set_rd_ff.score) >= sthr_ff;

   always_comb begin
      unique case (state_ff)
         ST_DECAY: sig_rd_a = dec_ff[SIG_WIDTH-1:0];
         ST_TRAIN: sig_rd_a = new_sig;
         default:  sig_rd_a = train_sig;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= row_w;
         set_mem[mem_wa] <= set_w;
      end
      line_rd_ff <= line_mem[cur_set];
      set_rd_ff <= set_mem[cur_set];
   end

   always_ff @(posedge clock) begin
      if (sig_we) sctr_ff[sig_wa] <= sig_wd;
      sig_rd_ff <= sctr_ff[sig_rd_a];
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_in = clr_ff;
      dec_in = dec_ff;
      sthr_in = sthr_ff;
      rthr_in = rthr_ff;
      sel_in = sel_ff;
      ucnt_in = ucnt_ff;
      ctr_new_in = ctr_new_ff;
      mem_we = 1'b0;
      mem_wa = cur_set;
      row_w = line_rd_ff;
      set_w = set_rd_ff;
      sig_we = 1'b0;
      sig_wa = sig_rd_a;
      sig_wd = sig_rd_ff;
      ins_v = RRPV_LONG;
      if (csr_valid) begin
         if (csr_index == CSR_STREAM_THR) sthr_in = signed'(csr_wdata);
         else rthr_in = csr_wdata[1:0];
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[SET_W-1:0];
            for (int w = 0; w < WAYS; w++) begin
               row_w.rrpv[w] = RRPV_LONG;
               row_w.sig[w] = '0;
            end
            set_w.prev = '0;
            set_w.score = '0;
            sig_we = clr_ff < (SET_W+1)'(NSIGS);
            sig_wa = clr_ff[SIG_WIDTH-1:0];
            sig_wd = 2'd1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SET_W+1)'(SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_SIGRD;
         ST_SIGRD: state_in = ST_TRAIN;
         ST_TRAIN: begin
            // train on the addressed counter while new_sig is read
            if (req_ff.cmd == CMD_UPDATE) begin
               sig_we = 1'b1;
               sig_wa = train_sig;
               if (req_ff.hit) sig_wd = (sig_rd_ff == 2'd3) ? 2'd3 : sig_rd_ff + 2'd1;
               else sig_wd = (sig_rd_ff == 2'd0) ? 2'd0 : sig_rd_ff - 2'd1;
               ctr_new_in = sig_wd;
            end
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            res_in.victim_way = '0;
            res_in.set_streaming = streaming;
            if (req_ff.cmd == CMD_VICTIM) begin
               res_in.victim_way = first_w;
               if (top_v != RRPV_MAX) begin
                  mem_we = 1'b1;
                  for (int w = 0; w < WAYS; w++)
                     row_w.rrpv[w] = line_rd_ff.rrpv[w] + (RRPV_MAX - top_v);
               end
               res_in.selector_now = sel_ff;
               state_in = ST_RESP;
            end else begin
               mem_we = 1'b1;
               ucnt_in = ucnt_nx;
               set_w.prev = req_ff.address;
               set_w.score = score_nx;
               if (req_ff.hit) begin
                  row_w.rrpv[cur_way] = RRPV_NEAR;
               end else begin
                  row_w.sig[cur_way] = new_sig;
                  if (streaming) begin
                     ins_v = ((req_ff.pc[1:0] ^ req_ff.address[1:0]) != 2'd0) ? RRPV_MAX
                                                                           : RRPV_LONG;
                  end else begin
                     if (ctr_eff >= rthr_ff)
                        ins_v = RRPV_NEAR;
                     else if (lead_s) ins_v = RRPV_LONG;
                     else if (lead_b || sel_ff < SEL_MID)
                        ins_v = brrip_far ? RRPV_MAX : RRPV_LONG;
                     else ins_v = RRPV_LONG;
                     if (lead_s && sel_ff != SEL_MAX) sel_in = sel_ff + 1'b1;
                     if (lead_b && sel_ff != '0) sel_in = sel_ff - 1'b1;
                  end
                  row_w.rrpv[cur_way] = ins_v;
               end
               res_in.selector_now = sel_in;
               dec_in = '0;
               state_in = (ucnt_nx == '0) ? ST_DECAY : ST_RESP;
            end
         end
         ST_DECAY: begin
            // read entry dec_ff, write back entry dec_ff - 1
            sig_we = dec_ff != '0;
            sig_wa = SIG_WIDTH'(dec_ff - 1'b1);
            sig_wd = (sig_rd_ff == 2'd0) ? 2'd0 : sig_rd_ff - 2'd1;
            dec_in = dec_ff + 1'b1;
            if (dec_ff == (SIG_WIDTH+1)'(NSIGS)) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff <= '0;
         dec_ff <= '0;
         sthr_ff <= 3'sd2;
         rthr_ff <= 2'd2;
         sel_ff <= SEL_MID;
         ucnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff <= clr_in;
         dec_ff <= dec_in;
         sthr_ff <= sthr_in;
         rthr_ff <= rthr_in;
         sel_ff <= sel_in;
         ucnt_ff <= ucnt_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      res_ff <= res_in;
      ctr_new_ff <= ctr_new_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   `SDR_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state_ff))
   `SDR_ASSERT_NEXT(a_accept_read, req_valid && req_ready, state_ff == ST_READ)
   `SDR_ASSERT_IMP(a_no_accept_busy, rsp_valid && !rsp_ready && state_ff == ST_RESP,
                   !req_ready)
   `SDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule
